// ----- rtl/kmp_pkg.sv -----
// Shared definitions for the KMP pattern matcher.
// Holds the sizing constants, opcodes and the result word type; no dependencies.
package kmp_pkg;

  // Default pattern capacity and fixed field widths.
  localparam int unsigned MAX_PATTERN_DEF = 64;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned TEXT_W          = 32;

  // Input opcodes.
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // One result word as it leaves the matcher.
  typedef struct packed {
    logic              match_found;
    logic [TEXT_W-1:0] match_start;
    logic              end_of_text;
    logic              error_flag;
  } kmp_result_t;

  // Address width for a store of the given depth (at least one bit).
  function automatic int unsigned idx_width(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/kmp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/kmp_ctrl.sv -----
// Sequencer of the KMP pattern matcher: loads the pattern, builds the failure
// links and walks the match state per text word. Uses kmp_pkg; drives two kmp_ram.
module kmp_ctrl #(
  parameter int unsigned MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
  localparam int unsigned IDX_W      = kmp_pkg::idx_width(MAX_PATTERN),
  localparam int unsigned LEN_W      = $clog2(MAX_PATTERN + 1),
  localparam int unsigned LINK_W     = IDX_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input word channel.
  input  logic                        in_valid,
  input  logic                        in_opcode,
  input  logic [kmp_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_last,
  output logic                        in_stall,
  // Result hand-off to the output register.
  input  logic                        res_free,
  output logic                        res_load,
  output kmp_pkg::kmp_result_t        res,
  // Shared read address for both stores.
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [kmp_pkg::BYTE_W-1:0]  ps_rd_data,
  input  logic [LINK_W-1:0]           fl_rd_data,
  // Pattern store write port.
  output logic                        ps_we,
  output logic [IDX_W-1:0]            ps_waddr,
  output logic [kmp_pkg::BYTE_W-1:0]  ps_wdata,
  // Failure link write port; the top bit of a link means "no link".
  output logic                        fl_we,
  output logic [IDX_W-1:0]            fl_waddr,
  output logic [LINK_W-1:0]           fl_wdata
);

  import kmp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BINIT = 3'd1;
  localparam logic [2:0] S_GETC0 = 3'd2;
  localparam logic [2:0] S_LOOP  = 3'd3;
  localparam logic [2:0] S_GETC  = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_MATCH = 3'd6;
  localparam logic [2:0] S_ERR   = 3'd7;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [2:0]        state_r,  state_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic              ready_r,  ready_nxt;
  logic [IDX_W-1:0]  ms_r,     ms_nxt;
  logic [TEXT_W-1:0] tidx_r,   tidx_nxt;
  logic [IDX_W-1:0]  pos_r,    pos_nxt;
  logic [LINK_W-1:0] head_r,   head_nxt;
  logic [BYTE_W-1:0] cpos_r,   cpos_nxt;
  logic [IDX_W-1:0]  st_r,     st_nxt;
  logic [BYTE_W-1:0] ch_r,     ch_nxt;
  logic              last_r,   last_nxt;

  logic              accept;
  logic [LEN_W-1:0]  eff_len;
  logic              hit;
  logic [LEN_W-1:0]  st_new;
  logic              found;
  logic              need_res;
  logic [TEXT_W:0]   end1;
  logic [TEXT_W:0]   start_full;
  logic [TEXT_W-1:0] start_idx;
  logic [TEXT_W-1:0] tidx_inc;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // A pattern word after a finished pattern starts over from an empty store.
  assign eff_len = ready_r ? '0 : len_r;

  // Match step arithmetic on the data read for the current probe.
  assign hit        = (ps_rd_data == ch_r);
  assign st_new     = hit ? (LEN_W'(st_r) + LEN_W'(1)) : '0;
  assign found      = (st_new == len_r);
  assign need_res   = found || last_r;
  assign end1       = {1'b0, tidx_r} + (TEXT_W + 1)'(1);
  assign start_full = end1 - (TEXT_W + 1)'(len_r);
  assign start_idx  = (end1 >= (TEXT_W + 1)'(len_r)) ? start_full[TEXT_W-1:0] : '0;
  assign tidx_inc   = (tidx_r == '1) ? tidx_r : (tidx_r + TEXT_W'(1));

  // Next-state and memory access logic.
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    ready_nxt = ready_r;
    ms_nxt    = ms_r;
    tidx_nxt  = tidx_r;
    pos_nxt   = pos_r;
    head_nxt  = head_r;
    cpos_nxt  = cpos_r;
    st_nxt    = st_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    ps_we     = 1'b0;
    ps_waddr  = eff_len[IDX_W-1:0];
    ps_wdata  = in_data_byte;
    fl_we     = 1'b0;
    fl_waddr  = pos_r;
    fl_wdata  = head_r;
    res_load  = 1'b0;
    res       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_opcode == OP_PATTERN) begin
          ready_nxt = 1'b0;
          len_nxt   = eff_len;
          if (ready_r) begin
            ms_nxt   = '0;
            tidx_nxt = '0;
          end
          // Words past the capacity are dropped.
          if (eff_len < MAX_LEN) begin
            ps_we   = 1'b1;
            len_nxt = eff_len + LEN_W'(1);
          end
          if (in_last) begin
            ms_nxt    = '0;
            tidx_nxt  = '0;
            state_nxt = S_BINIT;
          end
        end else if (accept) begin
          ch_nxt   = in_data_byte;
          last_nxt = in_last;
          if (!ready_r || len_r == '0) begin
            state_nxt = S_ERR;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ms_r;
            st_nxt    = ms_r;
            state_nxt = S_MATCH;
          end
        end
      end

      // Link 0 is always "no link"; fetch the first pattern byte.
      S_BINIT: begin
        fl_we     = 1'b1;
        fl_waddr  = '0;
        fl_wdata  = {1'b1, {IDX_W{1'b0}}};
        rd_en     = 1'b1;
        rd_addr   = '0;
        pos_nxt   = '0;
        head_nxt  = {1'b1, {IDX_W{1'b0}}};
        state_nxt = S_GETC0;
      end

      S_GETC0: begin
        cpos_nxt  = ps_rd_data;
        state_nxt = S_LOOP;
      end

      // Chase the head back through the links until it matches or runs out; finish once every position has a link.
      S_LOOP: begin
        if ((LEN_W'(pos_r) + LEN_W'(1)) >= len_r) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (!head_r[IDX_W] && cpos_r != ps_rd_data) begin
          head_nxt = fl_rd_data;
          if (!fl_rd_data[IDX_W]) begin
            rd_en   = 1'b1;
            rd_addr = fl_rd_data[IDX_W-1:0];
          end
        end else begin
          pos_nxt   = pos_r + IDX_W'(1);
          head_nxt  = head_r[IDX_W] ? '0 : {1'b0, head_r[IDX_W-1:0] + IDX_W'(1)};
          rd_en     = 1'b1;
          rd_addr   = pos_r + IDX_W'(1);
          state_nxt = S_GETC;
        end
      end

      S_GETC: begin
        cpos_nxt  = ps_rd_data;
        rd_en     = 1'b1;
        rd_addr   = head_r[IDX_W-1:0];
        state_nxt = S_LINK;
      end

      // An equal next character inherits the head's own link.
      S_LINK: begin
        fl_we     = 1'b1;
        fl_waddr  = pos_r;
        fl_wdata  = (ps_rd_data != cpos_r) ? head_r : fl_rd_data;
        state_nxt = S_LOOP;
      end

      // Compare and follow the link on a mismatch, one probe per cycle; a result waits for a free output register.
      S_MATCH: begin
        if (!hit && !fl_rd_data[IDX_W]) begin
          st_nxt  = fl_rd_data[IDX_W-1:0];
          rd_en   = 1'b1;
          rd_addr = fl_rd_data[IDX_W-1:0];
        end else if (!need_res || res_free) begin
          ms_nxt           = found ? '0 : st_new[IDX_W-1:0];
          tidx_nxt         = last_r ? '0 : tidx_inc;
          if (last_r) begin
            ms_nxt = '0;
          end
          res_load         = need_res;
          res.match_found  = found;
          res.match_start  = found ? start_idx : '0;
          res.end_of_text  = last_r;
          res.error_flag   = 1'b0;
          state_nxt        = S_IDLE;
        end
      end

      S_ERR: begin
        if (res_free) begin
          res_load        = 1'b1;
          res.end_of_text = last_r;
          res.error_flag  = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      ready_r <= 1'b0;
      ms_r    <= '0;
      tidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ready_r <= ready_nxt;
      ms_r    <= ms_nxt;
      tidx_r  <= tidx_nxt;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    head_r <= head_nxt;
    cpos_r <= cpos_nxt;
    st_r   <= st_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- rtl/kmp_pattern_matcher_core.sv -----
// Top level of the streaming KMP pattern matcher.
// Depends on kmp_pkg, kmp_ram and kmp_ctrl.
//
// Pattern words (opcode 0) are taken one per cycle and written to the pattern
// store; the word marked last starts the failure link build, which runs
// through the link store with the input stalled meanwhile. A text word
// (opcode 1) follows failure links on a mismatch, each probe being one
// registered read of both stores at the same address. A text word without a
// finished pattern gives an error result. Results wait in an output register;
// a match start comes from the saturating 32-bit text index.
module kmp_pattern_matcher_core #(
  parameter int unsigned MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_opcode,
  input  logic [kmp_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                               in_last,
  output logic                               in_stall,
  output logic                               out_valid,
  output logic                               out_match_found,
  output logic [kmp_pkg::TEXT_W-1:0]         out_match_start,
  output logic                               out_end_of_text,
  output logic                               out_error_flag,
  input  logic                               out_stall
);

  import kmp_pkg::*;

  localparam int unsigned IDX_W  = idx_width(MAX_PATTERN);
  localparam int unsigned LINK_W = IDX_W + 1;

  logic              res_free;
  logic              res_load;
  kmp_result_t       res;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] ps_rd_data;
  logic [LINK_W-1:0] fl_rd_data;
  logic              ps_we;
  logic [IDX_W-1:0]  ps_waddr;
  logic [BYTE_W-1:0] ps_wdata;
  logic              fl_we;
  logic [IDX_W-1:0]  fl_waddr;
  logic [LINK_W-1:0] fl_wdata;

  logic              out_valid_r, out_valid_nxt;
  kmp_result_t       out_res_r;

  // Pattern byte store.
  kmp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk     (clk),
    .wr_en   (ps_we),
    .wr_addr (ps_waddr),
    .wr_data (ps_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ps_rd_data)
  );

  // Failure link store.
  kmp_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_PATTERN)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (fl_we),
    .wr_addr (fl_waddr),
    .wr_data (fl_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (fl_rd_data)
  );

  kmp_ctrl #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .in_stall     (in_stall),
    .res_free     (res_free),
    .res_load     (res_load),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .ps_rd_data   (ps_rd_data),
    .fl_rd_data   (fl_rd_data),
    .ps_we        (ps_we),
    .ps_waddr     (ps_waddr),
    .ps_wdata     (ps_wdata),
    .fl_we        (fl_we),
    .fl_waddr     (fl_waddr),
    .fl_wdata     (fl_wdata)
  );

  // The output register can take a new word when empty or being emptied.
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_res_r.match_found;
  assign out_match_start = out_res_r.match_start;
  assign out_end_of_text = out_res_r.end_of_text;
  assign out_error_flag  = out_res_r.error_flag;

endmodule

// ----- bench/kmp_match_checker.sv -----
// Result checker for the KMP pattern matcher testbench.
// Watches both channels of kmp_pattern_matcher_core and predicts each result word.
// Depends on kmp_pkg for the opcodes and the result word type.
module kmp_match_checker #(
  parameter int unsigned MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_opcode,
  input  logic [kmp_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_last,
  input  logic                       in_stall,
  input  logic                       out_valid,
  input  logic                       out_match_found,
  input  logic [kmp_pkg::TEXT_W-1:0] out_match_start,
  input  logic                       out_end_of_text,
  input  logic                       out_error_flag,
  input  logic                       out_stall,
  output int                         mismatch_count,
  output int                         open_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kmp_pkg::*;

  // Private copy of the matcher state.
  logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
  int                link_mem [MAX_PATTERN];
  int unsigned       pat_len = 0;
  bit                pat_ready = 1'b0;
  int                scan_state = 0;
  logic [TEXT_W-1:0] text_pos = '0;

  // Result words predicted but not yet seen, oldest first.
  kmp_result_t       due_results [$];
  int                result_seq = 0;

  task automatic log_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $realtime, result_seq, what);
    mismatch_count++;
  endtask

  // Failure links with the improvement: a link that would lead to the same
  // next character takes over that entry's own link instead.
  function automatic void build_skip_links();
    int pos;
    int head;
    pos  = 0;
    head = -1;
    if (pat_len == 0) return;
    link_mem[0] = -1;
    while (pos < int'(pat_len) - 1) begin
      while (head >= 0 && pat_mem[pos] != pat_mem[head]) head = link_mem[head];
      pos++;
      head++;
      if (pat_mem[pos] != pat_mem[head]) link_mem[pos] = head;
      else link_mem[pos] = link_mem[head];
    end
  endfunction

  // Apply one accepted word to the state and queue the result it causes.
  task automatic advance_search(input logic op, input logic [BYTE_W-1:0] ch,
                                input logic lst);
    kmp_result_t res;
    int          st;
    bit          found;
    logic [32:0] end_pos;
    res   = '0;
    found = 1'b0;
    if (op == OP_PATTERN) begin
      // A pattern word on a finished pattern starts a fresh one.
      if (pat_ready) begin
        pat_ready  = 1'b0;
        pat_len    = 0;
        scan_state = 0;
        text_pos   = '0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_mem[pat_len] = ch;
        pat_len++;
      end
      if (lst) begin
        build_skip_links();
        pat_ready  = 1'b1;
        scan_state = 0;
        text_pos   = '0;
      end
    end else if (!pat_ready || pat_len == 0) begin
      // Text with no finished pattern is flagged and leaves the state alone.
      res.end_of_text = lst;
      res.error_flag  = 1'b1;
      due_results.push_back(res);
    end else begin
      st = scan_state;
      if (st < 0 || st >= int'(pat_len)) st = 0;
      forever begin
        if (pat_mem[st] == ch) begin
          st++;
          break;
        end
        st = link_mem[st];
        if (st < 0) begin
          st = 0;
          break;
        end
      end
      // A full match restarts from the beginning, so matches never overlap.
      if (st == int'(pat_len)) begin
        end_pos = {1'b0, text_pos} + 33'd1;
        found = 1'b1;
        res.match_found = 1'b1;
        res.match_start = (end_pos >= pat_len) ? TEXT_W'(end_pos - pat_len) : '0;
        st = 0;
      end
      scan_state = st;
      if (text_pos != '1) text_pos++;
      if (lst) begin
        scan_state = 0;
        text_pos   = '0;
      end
      if (found || lst) begin
        res.end_of_text = lst;
        due_results.push_back(res);
      end
    end
  endtask

  // Compare one accepted result word with the oldest prediction.
  task automatic check_result();
    kmp_result_t want;
    result_seq++;
    if (due_results.size() == 0) begin
      log_mismatch($sformatf("unexpected word found=%0b start=%0d eot=%0b err=%0b",
                             out_match_found, out_match_start, out_end_of_text,
                             out_error_flag));
      return;
    end
    want = due_results.pop_front();
    if (out_match_found !== want.match_found)
      log_mismatch($sformatf("match_found %0b, expected %0b", out_match_found,
                             want.match_found));
    if (out_match_start !== want.match_start)
      log_mismatch($sformatf("match_start %0d, expected %0d", out_match_start,
                             want.match_start));
    if (out_end_of_text !== want.end_of_text)
      log_mismatch($sformatf("end_of_text %0b, expected %0b", out_end_of_text,
                             want.end_of_text));
    if (out_error_flag !== want.error_flag)
      log_mismatch($sformatf("error_flag %0b, expected %0b", out_error_flag,
                             want.error_flag));
  endtask

  // Both channels are sampled at the clock edge where their handshakes land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) advance_search(in_opcode, in_data_byte, in_last);
      if (out_valid && !out_stall) check_result();
    end
    open_count <= due_results.size();
  end

endmodule

// ----- bench/kmp_pattern_matcher_core_test.sv -----
// Stimulus and verdict for the KMP pattern matcher.
// Drives kmp_pattern_matcher_core with pattern and text words and relies on
// kmp_match_checker for prediction; depends on kmp_pkg.
module kmp_pattern_matcher_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kmp_pkg::*;

  localparam int unsigned MAX_PATTERN = MAX_PATTERN_DEF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_opcode = OP_PATTERN;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_last = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_match_found;
  logic [TEXT_W-1:0] out_match_start;
  logic              out_end_of_text;
  logic              out_error_flag;
  logic              out_stall = 1'b0;
  int                mismatch_count;
  int                open_count;

  // Idle rates in percent, and the words sent so far.
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                word_count = 0;
  int                long_left = 4;
  logic [BYTE_W-1:0] cur_pat [$];

  kmp_pattern_matcher_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_opcode(in_opcode),
    .in_data_byte(in_data_byte),
    .in_last(in_last),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_match_found(out_match_found),
    .out_match_start(out_match_start),
    .out_end_of_text(out_end_of_text),
    .out_error_flag(out_error_flag),
    .out_stall(out_stall)
  );

  kmp_match_checker #(
    .MAX_PATTERN(MAX_PATTERN)
  ) result_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_opcode(in_opcode),
    .in_data_byte(in_data_byte),
    .in_last(in_last),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_match_found(out_match_found),
    .out_match_start(out_match_start),
    .out_end_of_text(out_end_of_text),
    .out_error_flag(out_error_flag),
    .out_stall(out_stall),
    .mismatch_count(mismatch_count),
    .open_count(open_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The result side stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one word; valid stays high after acceptance so back-to-back words
  // never lower and raise it within one step.
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] ch,
                           input logic lst, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= ch;
    in_last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) word_count++;
  endtask

  // Mostly a two-letter alphabet so that failure links get exercised.
  function automatic logic [BYTE_W-1:0] pick_char(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
    int r;
    r = $urandom_range(99);
    if (r < 45) return a;
    if (r < 90) return b;
    return BYTE_W'($urandom_range(255));
  endfunction

  // Bytes past the store depth are dropped by the block and not counted.
  task automatic send_pattern(input int len, input logic [BYTE_W-1:0] a,
                              input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] ch;
    cur_pat.delete();
    for (int i = 0; i < len; i++) begin
      ch = pick_char(a, b);
      if (i < int'(MAX_PATTERN)) cur_pat.push_back(ch);
      send_word(OP_PATTERN, ch, i == len - 1, i < int'(MAX_PATTERN));
    end
  endtask

  // Text with copies of the current pattern planted, some of them spoiled.
  task automatic send_text(input int len, input logic [BYTE_W-1:0] a,
                           input logic [BYTE_W-1:0] b, input bit closed);
    logic [BYTE_W-1:0] txt [$];
    int                n;
    while (txt.size() < len) begin
      n = cur_pat.size();
      if ($urandom_range(99) < 35 && n > 0 && n <= len - txt.size()) begin
        foreach (cur_pat[k]) txt.push_back(cur_pat[k]);
        if ($urandom_range(99) < 30) txt[txt.size() - 1] = pick_char(a, b);
      end else begin
        txt.push_back(pick_char(a, b));
      end
    end
    foreach (txt[k]) send_word(OP_TEXT, txt[k], closed && k == txt.size() - 1, 1'b1);
  endtask

  // A well-formed pattern followed by one to three texts.
  task automatic run_search();
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    int                plen;
    a = BYTE_W'($urandom_range(255));
    b = ($urandom_range(1) == 1) ? BYTE_W'($urandom_range(255))
                                 : a ^ BYTE_W'(1 << $urandom_range(7));
    plen = ($urandom_range(99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 20);
    send_pattern(plen, a, b);
    repeat ($urandom_range(1, 3))
      send_text($urandom_range(1, 40), a, b, $urandom_range(99) >= 8);
  endtask

  // Patterns at and past the store depth; the last byte still closes them.
  task automatic run_long(input int len);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    a = BYTE_W'($urandom_range(255));
    b = BYTE_W'($urandom_range(255));
    send_pattern(len, a, b);
    send_text($urandom_range(64, 90), a, b, 1'b1);
  endtask

  // Unfinished pattern interrupted by text, which must come back flagged.
  task automatic run_broken();
    repeat ($urandom_range(1, 3))
      send_word(OP_PATTERN, BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
    repeat ($urandom_range(1, 3))
      send_word(OP_TEXT, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_word(1'($urandom_range(1)), BYTE_W'($urandom_range(255)),
                1'($urandom_range(1)), 1'b1);
  endtask

  task automatic run_phase(input int in_idle, input int out_idle, input int quota);
    int goal;
    int r;
    idle_pct  = in_idle;
    stall_pct = out_idle;
    goal      = word_count + quota;
    while (word_count < goal) begin
      r = $urandom_range(99);
      if (r < 6) begin
        run_noise();
      end else if (r < 12) begin
        run_broken();
      end else if (r < 15 && long_left > 0) begin
        run_long(63 + long_left);
        long_left--;
      end else begin
        run_search();
      end
    end
  endtask

  // Main sequence: reset, directed words, three random phases, drain, verdict.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Text before any pattern is flagged, with and without the last mark.
    send_word(OP_TEXT, 8'h00, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'hFF, 1'b1, 1'b1);
    // Text in the middle of an unfinished pattern is flagged as well.
    send_word(OP_PATTERN, 8'h00, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'h5A, 1'b0, 1'b1);
    send_word(OP_PATTERN, 8'hFF, 1'b0, 1'b1);
    send_word(OP_PATTERN, 8'h00, 1'b1, 1'b1);
    // One match, then no overlapping second match; the last byte reports none.
    send_word(OP_TEXT, 8'h00, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'hFF, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'h00, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'hFF, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'h00, 1'b1, 1'b1);
    // A new one-byte pattern replaces the ready one; match on the last byte.
    send_word(OP_PATTERN, 8'h80, 1'b1, 1'b1);
    send_word(OP_TEXT, 8'h80, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'h7F, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'h80, 1'b1, 1'b1);
    // A pattern word mid-text drops the pattern and clears the text index.
    send_word(OP_TEXT, 8'h80, 1'b0, 1'b1);
    send_word(OP_PATTERN, 8'h01, 1'b0, 1'b1);
    send_word(OP_PATTERN, 8'h01, 1'b1, 1'b1);
    send_word(OP_TEXT, 8'h01, 1'b0, 1'b1);
    send_word(OP_TEXT, 8'h01, 1'b1, 1'b1);

    run_phase(34, 76, 250);
    run_phase(76, 34, 250);
    run_phase(0, 0, 250);
    in_valid <= 1'b0;

    // Drain what is still on its way, then give the block time to misbehave.
    for (int w = 0; w < 20000 && open_count != 0; w++) @(posedge clk);
    repeat (600) @(posedge clk);

    if (mismatch_count == 0 && open_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_ctrl.sv
rtl/kmp_pattern_matcher_core.sv
bench/kmp_match_checker.sv
bench/kmp_pattern_matcher_core_test.sv
